// ===== hw/rtl/sha_pkg.sv =====
// SHA-256 engine package: round constants, initial hash values, the sigma
// functions and the command/status structs between controller and datapath.
// No dependencies.
package sha_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned Words   = 8;
  localparam int unsigned Rounds  = 64;
  localparam int unsigned BlockW  = 512;

  // byte source for the block shift register
  localparam logic [1:0] SRC_DATA = 2'd0;
  localparam logic [1:0] SRC_PAD  = 2'd1;
  localparam logic [1:0] SRC_ZERO = 2'd2;
  localparam logic [1:0] SRC_LEN  = 2'd3;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [WordW-1:0] IV [Words] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WordW-1:0] K [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic       shift_en;   // shift one byte into the block register
    logic [1:0] shift_src;
    logic       count_bits; // add 8 to the message bit count
    logic       load_vars;  // copy chain words into the working variables
    logic       round_en;
    logic       add_chain;
    logic       out_advance;
    logic       reinit;     // back to initial hash, zero fill and count
  } cmd_t;

  typedef struct packed {
    logic fill_last;   // fill is 63: next shift completes a block
    logic fill_pad;    // fill is 55: next shift reaches the length field
    logic round_last;
    logic word_last;
  } stat_t;

  function automatic logic [WordW-1:0] big_sigma0(input logic [WordW-1:0] x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [WordW-1:0] big_sigma1(input logic [WordW-1:0] x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [WordW-1:0] small_sigma0(input logic [WordW-1:0] x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [WordW-1:0] small_sigma1(input logic [WordW-1:0] x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

// ===== hw/rtl/sha_dpath.sv =====
// SHA-256 datapath: block shift register doubling as the message schedule
// window, working variables, chain words, fill and bit counters.
// Depends on sha_pkg.
module sha_dpath (
  input  logic                clk,
  input  logic                rst,
  input  sha_pkg::cmd_t       cmd,
  input  logic [7:0]          data_byte,
  output sha_pkg::stat_t      stat,
  output logic [31:0]         digest_word,
  output logic [2:0]          word_index
);
  import sha_pkg::*;

  logic [BlockW-1:0] win;
  logic [WordW-1:0]  v [Words];
  logic [WordW-1:0]  chain [Words];
  logic [5:0]        fill;
  logic [63:0]       bit_count;
  logic [5:0]        rnd;
  logic [2:0]        out_idx;

  logic [7:0]        byte_in;
  logic [WordW-1:0]  w_cur;
  logic [WordW-1:0]  w_new;
  logic [WordW-1:0]  t1;
  logic [WordW-1:0]  t2;
  logic [WordW-1:0]  ch;
  logic [WordW-1:0]  maj;

  always_comb begin
    case (cmd.shift_src)
      SRC_DATA: byte_in = data_byte;
      SRC_PAD:  byte_in = PAD_BYTE;
      SRC_ZERO: byte_in = 8'd0;
      SRC_LEN:  byte_in = 8'(bit_count >> {~fill[2:0], 3'b000});
      default:  byte_in = 8'd0;
    endcase
  end

  // window word j holds w[t+j]; word 0 sits at the top of the register
  assign w_cur = win[511:480];
  assign w_new = w_cur + small_sigma0(win[479:448]) + win[223:192]
               + small_sigma1(win[63:32]);

  assign ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1  = v[7] + big_sigma1(v[4]) + ch + K[rnd] + w_cur;
  assign t2  = big_sigma0(v[0]) + maj;

  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      win <= {win[BlockW-9:0], byte_in};
    end else if (cmd.round_en) begin
      win <= {win[BlockW-33:0], w_new};
    end
    if (cmd.load_vars) begin
      v <= chain;
    end else if (cmd.round_en) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.reinit) begin
      chain     <= IV;
      fill      <= 6'd0;
      bit_count <= 64'd0;
      out_idx   <= 3'd0;
    end else begin
      if (cmd.add_chain) begin
        for (int i = 0; i < Words; i++) begin
          chain[i] <= chain[i] + v[i];
        end
      end
      if (cmd.shift_en) begin
        fill <= fill + 6'd1;
      end
      if (cmd.count_bits) begin
        bit_count <= bit_count + 64'd8;
      end
      if (cmd.out_advance) begin
        out_idx <= out_idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load_vars) begin
      rnd <= 6'd0;
    end else if (cmd.round_en) begin
      rnd <= rnd + 6'd1;
    end
  end

  assign stat.fill_last  = (fill == 6'd63);
  assign stat.fill_pad   = (fill == 6'd55);
  assign stat.round_last = (rnd == 6'd63);
  assign stat.word_last  = (out_idx == 3'd7);

  assign digest_word = chain[out_idx];
  assign word_index  = out_idx;

endmodule

// ===== hw/rtl/sha_ctrl.sv =====
// SHA-256 controller: byte intake, padding sequence, compression rounds and
// digest readout. Depends on sha_pkg.
module sha_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           byte_present,
  input  logic           message_end,
  output logic           out_valid,
  input  logic           out_ready,
  input  sha_pkg::stat_t stat,
  output sha_pkg::cmd_t  cmd
);
  import sha_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ZERO  = 3'd2;
  localparam logic [2:0] S_LEN   = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_ROUND = 3'd5;
  localparam logic [2:0] S_ADD   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] after;       // where to go once the running compression ends
  logic [2:0] after_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      after <= S_IDLE;
    end else begin
      state <= state_next;
      after <= after_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd        = '0;
    state_next = state;
    after_next = after;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (byte_present) begin
            cmd.shift_en   = 1'b1;
            cmd.shift_src  = SRC_DATA;
            cmd.count_bits = 1'b1;
          end
          if (byte_present && stat.fill_last) begin
            state_next = S_LOAD;
            after_next = message_end ? S_PAD : S_IDLE;
          end else if (message_end) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.shift_en  = 1'b1;
        cmd.shift_src = SRC_PAD;
        if (stat.fill_last) begin
          state_next = S_LOAD;
          after_next = S_ZERO;
        end else if (stat.fill_pad) begin
          state_next = S_LEN;
        end else begin
          state_next = S_ZERO;
        end
      end
      S_ZERO: begin
        cmd.shift_en  = 1'b1;
        cmd.shift_src = SRC_ZERO;
        if (stat.fill_last) begin
          state_next = S_LOAD;
          after_next = S_ZERO;
        end else if (stat.fill_pad) begin
          state_next = S_LEN;
        end
      end
      S_LEN: begin
        cmd.shift_en  = 1'b1;
        cmd.shift_src = SRC_LEN;
        if (stat.fill_last) begin
          state_next = S_LOAD;
          after_next = S_OUT;
        end
      end
      S_LOAD: begin
        cmd.load_vars = 1'b1;
        state_next    = S_ROUND;
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        if (stat.round_last) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add_chain = 1'b1;
        state_next    = after;
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.out_advance = 1'b1;
          if (stat.word_last) begin
            cmd.reinit = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/sha256_hash_engine_core.sv =====
// SHA-256 hash engine top level: controller plus datapath.
// Depends on sha_pkg, sha_ctrl and sha_dpath.
//
// Usage: feed a message one item at a time on the input channel. An item
// with byte_present high appends data_byte; an item with message_end high
// closes the message after its byte (an end mark alone is fine, also for
// the empty message). After the end mark the engine pads the block and
// emits eight 32-bit digest words, word_index 0 (most significant) first,
// last_word high on the eighth, then returns to the initial hash state.
// Throughput: one byte item per cycle while a block fills; every full
// block then goes through compression (one load, 64 rounds at one round
// per cycle, one chain update).
// Finalization shifts in padding and length at one byte per cycle with
// one or two compressions, then the digest words follow.
// in_ready is low while the engine pads, compresses or shows the digest.
// A stalled receiver simply holds the current word; nothing is dropped.
// Reset (synchronous) restores the initial hash, zero fill and bit count.
module sha256_hash_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        message_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sha_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .byte_present (byte_present),
    .message_end  (message_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  sha_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (data_byte),
    .stat        (stat),
    .digest_word (digest_word),
    .word_index  (word_index)
  );

  assign last_word = stat.word_last;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output channels active together");

  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_word |=> in_ready)
    else $error("engine not idle after last digest word");

  a_word_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_word |=>
      out_valid && (word_index == $past(word_index) + 3'd1))
    else $error("digest words out of order");

endmodule
